>>> src/absr_pkg.sv
// Shared types, constants and color helper for the attribute bitmap scanline renderer.
// Used by absr_vram and attribute_bitmap_scanline_renderer; no dependencies.
package absr_pkg;

    // Frame geometry
    localparam int VBLANK_LINES     = 16;
    localparam int TOP_BORDER_LINES = 48;
    localparam int BORDER_CELLS     = 6;
    localparam int DISPLAY_ROWS     = 192;
    localparam int DISPLAY_CELLS    = 32;

    localparam int CELL_W       = $clog2(DISPLAY_CELLS);
    localparam int BITMAP_BYTES = DISPLAY_ROWS * DISPLAY_CELLS;
    localparam int MEM_BYTES    = BITMAP_BYTES + (DISPLAY_ROWS / 8) * DISPLAY_CELLS;
    localparam int ADDR_W       = 13;

    localparam int DISP_FIRST_LINE = VBLANK_LINES + TOP_BORDER_LINES;
    localparam int DISP_END_LINE   = DISP_FIRST_LINE + DISPLAY_ROWS;
    localparam int DISP_END_CELL   = BORDER_CELLS + DISPLAY_CELLS;

    // Field widths
    localparam int SCAN_W  = 9;
    localparam int COL_W   = 6;
    localparam int LEVEL_W = 8;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Configuration register indexes
    localparam logic CFG_NORMAL_LEVEL = 1'b0;
    localparam logic CFG_BRIGHT_LEVEL = 1'b1;

    localparam logic [LEVEL_W-1:0] NORMAL_LEVEL_RST = 8'hcd;
    localparam logic [LEVEL_W-1:0] BRIGHT_LEVEL_RST = 8'hff;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] bm_addr;
        logic [ADDR_W-1:0] at_addr;
    } vram_req_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // Color index bits: 0 blue, 1 red, 2 green
    function automatic rgb_t color_of(input logic [2:0] idx, input logic [LEVEL_W-1:0] lvl);
        rgb_t c;
        c.red   = idx[1] ? lvl : '0;
        c.green = idx[2] ? lvl : '0;
        c.blue  = idx[0] ? lvl : '0;
        return c;
    endfunction

endpackage

>>> src/absr_vram.sv
// Display memory: 6912 bytes, one write port and two registered read ports
// (bitmap byte and attribute byte). Depends on absr_pkg.
module absr_vram (
    input  logic                aclk,
    input  absr_pkg::vram_req_t req,
    output logic [7:0]          bm_data,
    output logic [7:0]          at_data
);
    import absr_pkg::*;

    logic [7:0] mem [MEM_BYTES];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            bm_data <= mem[req.bm_addr];
            at_data <= mem[req.at_addr];
        end
    end

endmodule

>>> src/attribute_bitmap_scanline_renderer.sv
// Attribute bitmap scanline renderer: 6912-byte display memory and pixel serializer.
// Depends on absr_pkg and absr_vram.
//
// Input channel (s_): opcode in s_tuser. A write transfer stores mem_data at
// mem_address (addresses past the memory are dropped) and yields nothing. A
// render transfer yields eight pixel transfers on m_, leftmost pixel first,
// m_tlast on the eighth. Renders in vertical blank yield nothing.
// Writes are taken one per cycle unless a render waits in the input register
// for the serializer. A render holds the serializer for eight output transfers;
// the next render enters it as the eighth pixel goes to the output register.
// A render passes the input register, the registered memory read, then the output register.
// A render issued after a write always sees that write.
// When m_tready is low the output register holds; the cell in the serializer and
// a render in the input register stay put, and s_tready drops once both are full.
// Reset (aresetn low, synchronous) empties the pipeline and sets the levels
// to 205 and 255; display memory keeps no reset value.
// Configuration: cfg_wr_en, cfg_index (0 normal level, 1 bright level),
// cfg_data; write only while idle.
module attribute_bitmap_scanline_renderer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [absr_pkg::LEVEL_W-1:0]       cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mem_address[12:0], mem_data[20:13], scanline[29:21], cell_column[35:30],
    // frame_count[43:36], border_color[46:44], zero [47]
    input  logic [absr_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // red[7:0], green[15:8], blue[23:16], pixel_x[32:24], line_y[41:33], zero [47:42]
    output logic [absr_pkg::M_TDATA_W-1:0]     m_tdata,
    // last_pixel
    output logic                               m_tlast
);
    import absr_pkg::*;

    // Configuration
    logic [LEVEL_W-1:0] normal_level_reg, bright_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_level_reg <= NORMAL_LEVEL_RST;
            bright_level_reg <= BRIGHT_LEVEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NORMAL_LEVEL: normal_level_reg <= cfg_data;
                CFG_BRIGHT_LEVEL: bright_level_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    logic              p1_valid_reg;
    logic              p1_op_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [7:0]        p1_data_reg;
    logic [SCAN_W-1:0] p1_scan_reg;
    logic [COL_W-1:0]  p1_col_reg;
    logic              p1_flash_reg;
    logic [2:0]        p1_border_reg;

    // Serializer cell
    logic              p2_valid_reg;
    logic              p2_disp_reg;
    logic              p2_flash_reg;
    logic [2:0]        p2_border_reg;
    logic [COL_W-1:0]  p2_col_reg;
    logic [SCAN_W-1:0] p2_liney_reg;
    logic [2:0]        pix_cnt_reg;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    logic out_load, p2_done, p2_free;
    logic p1_needs_p2, p1_adv, p1_in_disp;
    logic [7:0]        sy;
    logic [CELL_W-1:0] cx;
    vram_req_t         vreq;
    logic [7:0]        bm_data, at_data;

    assign out_load    = p2_valid_reg && (!m_tvalid_reg || m_tready);
    assign p2_done     = out_load && (pix_cnt_reg == 3'd7);
    assign p2_free     = !p2_valid_reg || p2_done;
    assign p1_needs_p2 = (p1_op_reg == OP_RENDER) && (p1_scan_reg >= SCAN_W'(VBLANK_LINES));
    assign p1_adv      = p1_valid_reg && (!p1_needs_p2 || p2_free);
    assign s_tready    = !p1_valid_reg || p1_adv;

    assign p1_in_disp = (p1_scan_reg >= SCAN_W'(DISP_FIRST_LINE)) &&
                        (p1_scan_reg <  SCAN_W'(DISP_END_LINE)) &&
                        (p1_col_reg  >= COL_W'(BORDER_CELLS)) &&
                        (p1_col_reg  <  COL_W'(DISP_END_CELL));

    always_comb begin
        logic [SCAN_W-1:0] sy_full;
        logic [COL_W-1:0]  cx_full;
        logic [7:0]        row;
        sy_full = p1_scan_reg - SCAN_W'(DISP_FIRST_LINE);
        cx_full = p1_col_reg - COL_W'(BORDER_CELLS);
        sy      = sy_full[7:0];
        cx      = cx_full[CELL_W-1:0];
        // Bitmap rows are stored third, pixel line, character row
        row     = {sy[7:6], sy[2:0], sy[5:3]};
        vreq.wr_en   = p1_valid_reg && (p1_op_reg == OP_WRITE) &&
                       (p1_addr_reg < ADDR_W'(MEM_BYTES));
        vreq.wr_addr = p1_addr_reg;
        vreq.wr_data = p1_data_reg;
        vreq.rd_en   = p1_adv && p1_needs_p2 && p1_in_disp;
        vreq.bm_addr = ADDR_W'({row, cx});
        vreq.at_addr = ADDR_W'(BITMAP_BYTES) + ADDR_W'({sy[7:3], cx});
    end

    absr_vram u_vram (
        .aclk    (aclk),
        .req     (vreq),
        .bm_data (bm_data),
        .at_data (at_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            p1_op_reg     <= s_tuser;
            p1_addr_reg   <= s_tdata[12:0];
            p1_data_reg   <= s_tdata[20:13];
            p1_scan_reg   <= s_tdata[29:21];
            p1_col_reg    <= s_tdata[35:30];
            p1_flash_reg  <= s_tdata[39];
            p1_border_reg <= s_tdata[46:44];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            pix_cnt_reg  <= '0;
        end else begin
            if (p2_free) begin
                p2_valid_reg <= p1_adv && p1_needs_p2;
                pix_cnt_reg  <= '0;
            end else if (out_load) begin
                pix_cnt_reg  <= pix_cnt_reg + 3'd1;
            end
        end
        if (p2_free && p1_adv && p1_needs_p2) begin
            p2_disp_reg   <= p1_in_disp;
            p2_flash_reg  <= p1_flash_reg;
            p2_border_reg <= p1_border_reg;
            p2_col_reg    <= p1_col_reg;
            p2_liney_reg  <= p1_scan_reg - SCAN_W'(VBLANK_LINES);
        end
    end

    // Pixel color for the current serializer position
    rgb_t pix_rgb;

    always_comb begin
        logic [2:0]         inkc, papc;
        logic [LEVEL_W-1:0] lvl;
        logic               bit_on;
        inkc   = at_data[2:0];
        papc   = at_data[5:3];
        lvl    = at_data[6] ? bright_level_reg : normal_level_reg;
        bit_on = bm_data[3'd7 - pix_cnt_reg];
        // Flash swaps ink and paper in the on phase
        if (at_data[7] && p2_flash_reg) begin
            inkc = at_data[5:3];
            papc = at_data[2:0];
        end
        if (!p2_disp_reg) begin
            pix_rgb = color_of(p2_border_reg, normal_level_reg);
        end else if (bit_on) begin
            pix_rgb = color_of(inkc, lvl);
        end else begin
            pix_rgb = color_of(papc, lvl);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= p2_valid_reg;
        end
        if (out_load) begin
            m_tdata_reg <= {6'b0, p2_liney_reg, p2_col_reg, pix_cnt_reg,
                            pix_rgb.blue, pix_rgb.green, pix_rgb.red};
            m_tlast_reg <= (pix_cnt_reg == 3'd7);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
